[design/affine_point_vector_transform_defines.svh]
// assertion macros for the affine point and vector transform
// included by the rtl files that carry assertions, no other dependencies
`ifndef AFFINE_POINT_VECTOR_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_VECTOR_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define APVT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apvt assertion failed");
// next-cycle implication, disabled in reset
`define APVT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apvt assertion failed");
`else
`define APVT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define APVT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/apvt_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the affine point and vector transform
// no dependencies
package apvt_pkg;

    localparam int COEF_WIDTH_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_WIDTH     = 32;
    localparam int FRAC_SHIFT      = 12;
    localparam int ONE_Q12         = 4096;
    localparam int NUM_ROWS        = 3;
    localparam int NUM_COLS        = 3;
    localparam int NUM_STAGES      = 4;
    localparam int CFG_INDEX_WIDTH = 3;

    // register map
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW0_COEFFS = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW1_COEFFS = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW2_COEFFS = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_X     = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Y     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHIFT_Z     = 3'd5;

    // opcode
    localparam logic OP_POINT  = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

endpackage

[design/affine_point_vector_transform.sv]
`timescale 1ns / 1ps
// four register stages: coordinate capture, products, rounded row sums, then the translated and saturated result
// throughput: one beat per cycle; every stage takes a new beat at each edge unless the output stalls
// a stalled output backs up stage by stage, nothing is dropped or repeated
// reset clears all stage valid bits, loads the identity matrix and zero translations
// depends on apvt_pkg and affine_point_vector_transform_defines.svh
`include "affine_point_vector_transform_defines.svh"

module affine_point_vector_transform
    import apvt_pkg::*;
#(
    parameter int COEF_WIDTH  = COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [((3*COEF_WIDTH > FIELD_WIDTH) ? 3*COEF_WIDTH : FIELD_WIDTH)-1:0] cfg_wdata,
    // input beat
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [FIELD_WIDTH-1:0]     in_x,
    input  logic signed [FIELD_WIDTH-1:0]     in_y,
    input  logic signed [FIELD_WIDTH-1:0]     in_z,
    input  logic                              opcode,
    // output beat
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [FIELD_WIDTH-1:0]     out_x,
    output logic signed [FIELD_WIDTH-1:0]     out_y,
    output logic signed [FIELD_WIDTH-1:0]     out_z,
    output logic                              overflow
);

    // working coordinate width, upper input bits are ignored
    localparam int W     = (COORD_WIDTH < FIELD_WIDTH) ? COORD_WIDTH : FIELD_WIDTH;
    localparam int ROW_W = 3 * COEF_WIDTH;
    // product, row sum, rounded sum and translated sum widths
    localparam int PW    = COEF_WIDTH + W;
    localparam int SW    = PW + 2;
    localparam int RW    = SW - FRAC_SHIFT;
    localparam int TW    = ((RW > W) ? RW : W) + 1;

    localparam logic [COEF_WIDTH-1:0] COEF_ONE   = COEF_WIDTH'(ONE_Q12);
    localparam logic signed [SW-1:0]  ROUND_HALF = SW'(1) <<< (FRAC_SHIFT - 1);
    localparam logic [W-1:0] SAT_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_LO = {1'b1, {(W-1){1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]       row_reg   [NUM_ROWS];
    logic [FIELD_WIDTH-1:0] shift_reg [NUM_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity: coefficient one on the diagonal
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                row_reg[r]   <= ROW_W'(COEF_ONE) << (r * COEF_WIDTH);
                shift_reg[r] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ROW0_COEFFS: row_reg[0]   <= cfg_wdata[ROW_W-1:0];
                REG_ROW1_COEFFS: row_reg[1]   <= cfg_wdata[ROW_W-1:0];
                REG_ROW2_COEFFS: row_reg[2]   <= cfg_wdata[ROW_W-1:0];
                REG_SHIFT_X:     shift_reg[0] <= cfg_wdata[FIELD_WIDTH-1:0];
                REG_SHIFT_Y:     shift_reg[1] <= cfg_wdata[FIELD_WIDTH-1:0];
                REG_SHIFT_Z:     shift_reg[2] <= cfg_wdata[FIELD_WIDTH-1:0];
                default:         ; // index beyond the map, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control
    // a stage loads when it is empty or the stage after it moves on
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;

    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            adv[s] = !valid_reg[s] || adv[s+1];
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: capture the coordinate beat
    // ------------------------------------------------------------------
    logic signed [W-1:0] coord_reg [NUM_COLS];
    logic                op0_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
        begin
            coord_reg[0] <= in_x[W-1:0];
            coord_reg[1] <= in_y[W-1:0];
            coord_reg[2] <= in_z[W-1:0];
            op0_reg      <= opcode;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: nine coefficient by coordinate products
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_next [NUM_ROWS][NUM_COLS];
    logic signed [PW-1:0] prod_reg  [NUM_ROWS][NUM_COLS];
    logic                 op1_reg;

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                prod_next[r][c] = PW'($signed(row_reg[r][c*COEF_WIDTH +: COEF_WIDTH]))
                                * PW'(coord_reg[c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1] && valid_reg[0])
        begin
            prod_reg <= prod_next;
            op1_reg  <= op0_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: row sums, round half up, floor shift by the fraction bits
    // ------------------------------------------------------------------
    logic signed [SW-1:0] sum_next [NUM_ROWS];
    logic signed [RW-1:0] rnd_reg  [NUM_ROWS];
    logic                 op2_reg;

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            sum_next[r] = SW'(prod_reg[r][0]) + SW'(prod_reg[r][1])
                        + SW'(prod_reg[r][2]) + ROUND_HALF;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2] && valid_reg[1])
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                // dropping the low bits is the arithmetic floor shift
                rnd_reg[r] <= sum_next[r][SW-1:FRAC_SHIFT];
            end
            op2_reg <= op1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: translation in point mode, saturation, output register
    // ------------------------------------------------------------------
    logic signed [TW-1:0] tr_next  [NUM_ROWS];
    logic [W-1:0]         res_next [NUM_ROWS];
    logic [NUM_ROWS-1:0]  sat_next;
    logic [W-1:0]         res_reg  [NUM_ROWS];
    logic                 ovf_reg;

    always_comb
    begin
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            tr_next[r] = TW'(rnd_reg[r]);
            if (op2_reg == OP_POINT)
            begin
                tr_next[r] = tr_next[r] + TW'($signed(shift_reg[r][W-1:0]));
            end
            // out of range when the bits above the sign are not all copies of it
            sat_next[r] = (|tr_next[r][TW-1:W-1]) && !(&tr_next[r][TW-1:W-1]);
            if (sat_next[r])
            begin
                res_next[r] = tr_next[r][TW-1] ? SAT_LO : SAT_HI;
            end
            else
            begin
                res_next[r] = tr_next[r][W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[3] && valid_reg[2])
        begin
            res_reg <= res_next;
            ovf_reg <= |sat_next;
        end
    end

    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_x     = FIELD_WIDTH'(res_reg[0]);
    assign out_y     = FIELD_WIDTH'(res_reg[1]);
    assign out_z     = FIELD_WIDTH'(res_reg[2]);
    assign overflow  = ovf_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // input only backs up when every stage is full and the output is held
    `APVT_ASSERT_IMP(a_ready_only_when_full, clk, rst_n, !in_ready, (&valid_reg) && !out_ready)
    // a stalled product stage keeps its beat
    `APVT_ASSERT_NXT(a_prod_stage_holds, clk, rst_n, valid_reg[1] && !adv[1], valid_reg[1])
    // a stalled rounding stage keeps its beat
    `APVT_ASSERT_NXT(a_rnd_stage_holds, clk, rst_n, valid_reg[2] && !adv[2], valid_reg[2])
    // a flagged result carries at least one clamped component
    `APVT_ASSERT_IMP(a_ovf_has_clamp, clk, rst_n, out_valid && overflow,
        res_reg[0] == SAT_HI || res_reg[0] == SAT_LO || res_reg[1] == SAT_HI
        || res_reg[1] == SAT_LO || res_reg[2] == SAT_HI || res_reg[2] == SAT_LO)

endmodule

[tb/apvt_checker.sv]
`timescale 1ns / 1ps
// checker for the affine point and vector transform: mirrors the config, predicts each beat
// depends on apvt_pkg only
module apvt_checker
    import apvt_pkg::*;
#(
    parameter int CFG_DATA_WIDTH = 48
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_wdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [FIELD_WIDTH-1:0]        in_x,
    input  logic [FIELD_WIDTH-1:0]        in_y,
    input  logic [FIELD_WIDTH-1:0]        in_z,
    input  logic                          opcode,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [FIELD_WIDTH-1:0]        out_x,
    input  logic [FIELD_WIDTH-1:0]        out_y,
    input  logic [FIELD_WIDTH-1:0]        out_z,
    input  logic                          overflow,
    output int                            fail_count,
    output int                            results_due
);

    localparam int     LANE_W    = COEF_WIDTH_DEF;
    localparam longint COORD_MAX = (longint'(1) << (FIELD_WIDTH - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) << (FIELD_WIDTH - 1));
    localparam longint HALF_LSB  = longint'(1) << (FRAC_SHIFT - 1);

    typedef struct packed {
        logic signed [FIELD_WIDTH-1:0] x;
        logic signed [FIELD_WIDTH-1:0] y;
        logic signed [FIELD_WIDTH-1:0] z;
        logic                          ovf;
    } xform_result_t;

    logic [3*LANE_W-1:0]    coef_rows [NUM_ROWS];
    logic [FIELD_WIDTH-1:0] shift_regs [NUM_ROWS];
    xform_result_t          expected_xforms [$];
    int                     fails;

    function automatic xform_result_t transform_coord(input logic [FIELD_WIDTH-1:0] cx,
                                                       input logic [FIELD_WIDTH-1:0] cy,
                                                       input logic [FIELD_WIDTH-1:0] cz,
                                                       input logic op);
        longint        coord [NUM_COLS];
        longint        acc;
        longint        coef;
        longint        comp [NUM_ROWS];
        xform_result_t res;
        coord[0] = longint'($signed(cx));
        coord[1] = longint'($signed(cy));
        coord[2] = longint'($signed(cz));
        res.ovf = 1'b0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            acc = 0;
            for (int c = 0; c < NUM_COLS; c++)
            begin
                coef = longint'($signed(coef_rows[r][c*LANE_W +: LANE_W]));
                acc += coef * coord[c];
            end
            // floor shift, so exact halves go upward
            acc = (acc + HALF_LSB) >>> FRAC_SHIFT;
            if (op == OP_POINT)
                acc += longint'($signed(shift_regs[r]));
            if (acc > COORD_MAX)
            begin
                acc = COORD_MAX;
                res.ovf = 1'b1;
            end
            else if (acc < COORD_MIN)
            begin
                acc = COORD_MIN;
                res.ovf = 1'b1;
            end
            comp[r] = acc;
        end
        res.x = comp[0][FIELD_WIDTH-1:0];
        res.y = comp[1][FIELD_WIDTH-1:0];
        res.z = comp[2][FIELD_WIDTH-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xform_result_t want;
        if (!rst_n)
        begin
            coef_rows[0]  = 48'(ONE_Q12);
            coef_rows[1]  = 48'(ONE_Q12) << LANE_W;
            coef_rows[2]  = 48'(ONE_Q12) << (2 * LANE_W);
            shift_regs[0] = '0;
            shift_regs[1] = '0;
            shift_regs[2] = '0;
            expected_xforms.delete();
            fails = 0;
            fail_count  <= 0;
            results_due <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ROW0_COEFFS: coef_rows[0]  = cfg_wdata[3*LANE_W-1:0];
                    REG_ROW1_COEFFS: coef_rows[1]  = cfg_wdata[3*LANE_W-1:0];
                    REG_ROW2_COEFFS: coef_rows[2]  = cfg_wdata[3*LANE_W-1:0];
                    REG_SHIFT_X:     shift_regs[0] = cfg_wdata[FIELD_WIDTH-1:0];
                    REG_SHIFT_Y:     shift_regs[1] = cfg_wdata[FIELD_WIDTH-1:0];
                    REG_SHIFT_Z:     shift_regs[2] = cfg_wdata[FIELD_WIDTH-1:0];
                    default: ;
                endcase
            end
            // output side first: a beat leaving now cannot be one entering now
            if (out_valid && out_ready)
            begin
                if (expected_xforms.size() == 0)
                begin
                    $error("result beat with no expected result");
                    fails++;
                end
                else
                begin
                    want = expected_xforms.pop_front();
                    if (out_x !== want.x)
                    begin
                        $error("out_x: expected %0d, actual %0d", want.x, $signed(out_x));
                        fails++;
                    end
                    if (out_y !== want.y)
                    begin
                        $error("out_y: expected %0d, actual %0d", want.y, $signed(out_y));
                        fails++;
                    end
                    if (out_z !== want.z)
                    begin
                        $error("out_z: expected %0d, actual %0d", want.z, $signed(out_z));
                        fails++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $error("overflow: expected %0b, actual %0b", want.ovf, overflow);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_xforms.push_back(transform_coord(in_x, in_y, in_z, opcode));
            fail_count  <= fails;
            results_due <= expected_xforms.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// stimulus and verdict for the affine point and vector transform
// depends on apvt_pkg, apvt_checker and the affine_point_vector_transform rtl
module testbench
    import apvt_pkg::*;
();

    localparam int CFG_DATA_WIDTH = 48;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_BEATS    = 229;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 10;

    // indexes past the register map, writes there must be ignored
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic [15:0] LANE_MAX  = 16'h7FFF;
    localparam logic [15:0] LANE_MIN  = 16'h8000;
    localparam logic [15:0] LANE_ONE  = 16'h1000;
    localparam logic [15:0] LANE_HALF = 16'h0800;
    localparam logic [31:0] COORD_HI  = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_LO  = 32'h8000_0000;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [FIELD_WIDTH-1:0]     in_x      = '0;
    logic [FIELD_WIDTH-1:0]     in_y      = '0;
    logic [FIELD_WIDTH-1:0]     in_z      = '0;
    logic                       opcode    = OP_POINT;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [FIELD_WIDTH-1:0]     out_x;
    logic [FIELD_WIDTH-1:0]     out_y;
    logic [FIELD_WIDTH-1:0]     out_z;
    logic                       overflow;

    int mismatch_count;
    int results_due;
    int cycle_count = 0;
    int burst_left  = 0;
    int ready_mode  = 0;
    int ready_left  = 0;

    always #5 clk = ~clk;

    affine_point_vector_transform u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_z      (in_z),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .overflow  (overflow)
    );

    apvt_checker #(.CFG_DATA_WIDTH(CFG_DATA_WIDTH)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .opcode      (opcode),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .overflow    (overflow),
        .fail_count  (mismatch_count),
        .results_due (results_due)
    );

    // watchdog, sized well above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver back-pressure: segments of random length, each with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_mode <= 0;
            ready_left <= 0;
        end
        else if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(1, 60);
            out_ready  <= 1'b1;
        end
        else
        begin
            ready_left <= ready_left - 1;
            case (ready_mode)
                0: out_ready <= 1'b1;                          // no stalls
                1: out_ready <= 1'($urandom_range(0, 1));      // coin toss
                2: out_ready <= ($urandom_range(0, 9) != 0);   // rare stalls
                default: out_ready <= (ready_left > 24);       // long stall run
            endcase
        end
    end

    // one input beat, held until accepted, then maybe a gap at the end of a burst
    task automatic send_beat(input logic [31:0] bx, input logic [31:0] by,
                             input logic [31:0] bz, input logic bop);
        int gap;
        in_valid <= 1'b1;
        in_x     <= bx;
        in_y     <= by;
        in_z     <= bz;
        opcode   <= bop;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 20);
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // sender holds off until every result is back, then the matrix is reloaded
    task automatic reload_matrix(input logic [47:0] r0, input logic [47:0] r1,
                                 input logic [47:0] r2, input logic [31:0] sx,
                                 input logic [31:0] sy, input logic [31:0] sz);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(REG_ROW0_COEFFS, r0);
        write_reg(REG_ROW1_COEFFS, r1);
        write_reg(REG_ROW2_COEFFS, r2);
        // junk above bit 31 of a translation is dropped by the block
        write_reg(REG_SHIFT_X, {16'($urandom), sx});
        write_reg(REG_SHIFT_Y, {16'($urandom), sy});
        write_reg(REG_SHIFT_Z, {16'($urandom), sz});
        write_reg(REG_UNMAPPED_LO, {$urandom, 16'($urandom)});
        write_reg(REG_UNMAPPED_HI, {$urandom, 16'($urandom)});
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_lane();
        case ($urandom_range(0, 7))
            0, 1:    return 16'($urandom);
            2, 3:    return 16'($urandom_range(0, 8191) - 4096);
            4:       return LANE_MAX;
            5:       return LANE_MIN;
            6:       return 16'h0000;
            default: return LANE_ONE;
        endcase
    endfunction

    function automatic logic [31:0] rand_shift();
        case ($urandom_range(0, 5))
            0, 1:    return $urandom;
            2:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            3:       return COORD_HI;
            4:       return COORD_LO;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6:          return $urandom_range(0, 2047) - 1024;
            7:          return COORD_HI;
            8:          return COORD_LO;
            default:    return 32'h0;
        endcase
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrix is identity with no translation
        send_beat(32'h0, 32'h0, 32'h0, OP_POINT);
        send_beat(COORD_HI, COORD_HI, COORD_HI, OP_POINT);
        send_beat(COORD_LO, COORD_LO, COORD_LO, OP_VECTOR);
        send_beat(COORD_HI, COORD_LO, 32'h0, OP_POINT);
        send_beat(32'h1, 32'hFFFF_FFFF, 32'h0001_0000, OP_VECTOR);
        send_beat($urandom, $urandom, $urandom, OP_POINT);

        // largest coefficients and translations, saturating upward and downward
        reload_matrix({3{LANE_MAX}}, {3{LANE_MAX}}, {3{LANE_MAX}},
                      COORD_HI, COORD_HI, COORD_HI);
        send_beat(32'h0, 32'h0, 32'h0, OP_POINT);
        send_beat(COORD_HI, COORD_HI, COORD_HI, OP_VECTOR);
        send_beat(COORD_LO, COORD_LO, COORD_LO, OP_POINT);
        send_beat(32'h1, 32'h1, 32'h1, OP_POINT);

        // most negative coefficients and translations
        reload_matrix({3{LANE_MIN}}, {3{LANE_MIN}}, {3{LANE_MIN}},
                      COORD_LO, COORD_LO, COORD_LO);
        send_beat(32'h0, 32'h0, 32'h0, OP_POINT);
        send_beat(32'h1, 32'h0, 32'h0, OP_VECTOR);
        send_beat(COORD_LO, COORD_LO, COORD_LO, OP_VECTOR);
        send_beat(COORD_HI, COORD_HI, COORD_HI, OP_POINT);

        // exact halves, including negative ones, to pin the rounding
        reload_matrix({32'h0, LANE_HALF}, {16'h0, 16'h0001, 16'h0}, {16'hFFFF, 32'h0},
                      32'h0000_0003, 32'hFFFF_FFFD, 32'h0);
        send_beat(32'hFFFF_FFFF, 32'hFFFF_F800, 32'h0000_0800, OP_VECTOR);
        send_beat(32'hFFFF_FFFD, 32'h0000_0800, 32'h0000_1800, OP_VECTOR);
        send_beat(32'h0000_0003, 32'hFFFF_F7FF, 32'hFFFF_F800, OP_POINT);
        send_beat(32'h0000_0001, 32'h0000_07FF, 32'h0000_0801, OP_POINT);

        // random part: a fresh matrix per phase, the last one at the extremes
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == RANDOM_PHASES - 1)
                reload_matrix({LANE_MAX, LANE_MIN, LANE_MAX}, {LANE_MIN, LANE_MAX, LANE_MIN},
                              {LANE_MAX, LANE_MAX, LANE_MIN}, COORD_HI, COORD_LO, 32'h0);
            else
                reload_matrix({rand_lane(), rand_lane(), rand_lane()},
                              {rand_lane(), rand_lane(), rand_lane()},
                              {rand_lane(), rand_lane(), rand_lane()},
                              rand_shift(), rand_shift(), rand_shift());
            for (int n = 0; n < PHASE_BEATS; n++)
                send_beat(rand_coord(), rand_coord(), rand_coord(),
                          $urandom_range(0, 1) ? OP_VECTOR : OP_POINT);
        end

        // drain, then let the pipeline settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
